// ----- sv/chc_pkg.sv -----
`default_nettype none

package chc_pkg;

   // item function codes
   typedef enum logic [1:0] {
      FUNC_HEADING   = 2'd0,
      FUNC_CAL_START = 2'd1,
      FUNC_CAL_DATA  = 2'd2,
      FUNC_CAL_END   = 2'd3
   } func_type;

   // configuration register indexes
   localparam logic [1:0] REG_TARGET = 2'd0;
   localparam logic [1:0] REG_HOLD   = 2'd1;
   localparam logic [1:0] REG_KP     = 2'd2;

   localparam logic [15:0] KP_RESET = 16'd256;
   localparam logic signed [15:0] TRACK_LOW_RESET  = 16'sh7FFF;
   localparam logic signed [15:0] TRACK_HIGH_RESET = 16'sh8000;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // centered vector width and cordic datapath width (vector scaled by 2^8 plus growth)
   localparam int CENTER_W = 18;
   localparam int CORDIC_W = 29;

   localparam int QUEUE_DEPTH = 2;

   localparam int TAB_DEPTH = 24;
   localparam int TAB_IW    = 5;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32
   localparam logic [31:0] ATAN_TURN_TAB [TAB_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic                       hdg;
      logic                       status;
      logic [15:0]                count;
      logic signed [CENTER_W-1:0] xc;
      logic signed [CENTER_W-1:0] yc;
   } entry_type;

   typedef struct packed {
      logic [15:0]        heading;
      logic               heading_valid;
      logic               drive_active;
      logic signed [15:0] heading_error;
      logic signed [23:0] turn_rate;
      logic               status;
      logic [15:0]        good_count;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/chc_front.sv -----
`default_nettype none

module chc_front
   import chc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [15:0] req_x_raw,
   input  wire logic signed [15:0] req_y_raw,
   input  wire logic               req_sample_ok,
   input  wire logic               queue_full,
   output logic                    entry_push,
   output entry_type               entry
);

   logic signed [15:0] cal_x_low_ff, cal_x_high_ff, cal_y_low_ff, cal_y_high_ff;
   logic signed [15:0] cal_x_low_in, cal_x_high_in, cal_y_low_in, cal_y_high_in;
   logic signed [15:0] track_x_low_ff, track_x_high_ff, track_y_low_ff, track_y_high_ff;
   logic signed [15:0] track_x_low_in, track_x_high_in, track_y_low_in, track_y_high_in;
   logic [15:0]        count_ff, count_in;

   logic                       accept;
   func_type                   func;
   logic                       status;
   logic signed [CENTER_W-1:0] x2, y2, x_bias, y_bias;

   assign full       = queue_full;
   assign accept     = push && !queue_full;
   assign entry_push = accept;
   assign func       = func_type'(req_func);

   // hard-iron centering: 2x - (high + low)
   assign x2     = {req_x_raw[15], req_x_raw, 1'b0};
   assign y2     = {req_y_raw[15], req_y_raw, 1'b0};
   assign x_bias = {{2{cal_x_high_ff[15]}}, cal_x_high_ff}
                 + {{2{cal_x_low_ff[15]}}, cal_x_low_ff};
   assign y_bias = {{2{cal_y_high_ff[15]}}, cal_y_high_ff}
                 + {{2{cal_y_low_ff[15]}}, cal_y_low_ff};

   always_comb begin
      cal_x_low_in    = cal_x_low_ff;
      cal_x_high_in   = cal_x_high_ff;
      cal_y_low_in    = cal_y_low_ff;
      cal_y_high_in   = cal_y_high_ff;
      track_x_low_in  = track_x_low_ff;
      track_x_high_in = track_x_high_ff;
      track_y_low_in  = track_y_low_ff;
      track_y_high_in = track_y_high_ff;
      count_in        = count_ff;
      status          = 1'b0;
      case (func)
         FUNC_HEADING: begin
         end
         FUNC_CAL_START: begin
            track_x_low_in  = TRACK_LOW_RESET;
            track_x_high_in = TRACK_HIGH_RESET;
            track_y_low_in  = TRACK_LOW_RESET;
            track_y_high_in = TRACK_HIGH_RESET;
            count_in        = '0;
         end
         FUNC_CAL_DATA: begin
            if (req_sample_ok) begin
               if (req_x_raw < track_x_low_ff)  track_x_low_in  = req_x_raw;
               if (req_x_raw > track_x_high_ff) track_x_high_in = req_x_raw;
               if (req_y_raw < track_y_low_ff)  track_y_low_in  = req_y_raw;
               if (req_y_raw > track_y_high_ff) track_y_high_in = req_y_raw;
               if (count_ff != COUNT_MAX) count_in = count_ff + 16'd1;
            end
         end
         FUNC_CAL_END: begin
            if (count_ff == '0) begin
               status = 1'b1;
            end else begin
               cal_x_low_in  = track_x_low_ff;
               cal_x_high_in = track_x_high_ff;
               cal_y_low_in  = track_y_low_ff;
               cal_y_high_in = track_y_high_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      entry.hdg    = (func == FUNC_HEADING) && req_sample_ok;
      entry.status = status;
      entry.count  = count_in;
      entry.xc     = x2 - x_bias;
      entry.yc     = y2 - y_bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_low_ff    <= '0;
         cal_x_high_ff   <= '0;
         cal_y_low_ff    <= '0;
         cal_y_high_ff   <= '0;
         track_x_low_ff  <= TRACK_LOW_RESET;
         track_x_high_ff <= TRACK_HIGH_RESET;
         track_y_low_ff  <= TRACK_LOW_RESET;
         track_y_high_ff <= TRACK_HIGH_RESET;
         count_ff        <= '0;
      end else if (accept) begin
         cal_x_low_ff    <= cal_x_low_in;
         cal_x_high_ff   <= cal_x_high_in;
         cal_y_low_ff    <= cal_y_low_in;
         cal_y_high_ff   <= cal_y_high_in;
         track_x_low_ff  <= track_x_low_in;
         track_x_high_ff <= track_x_high_in;
         track_y_low_ff  <= track_y_low_in;
         track_y_high_ff <= track_y_high_in;
         count_ff        <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/chc_queue.sv -----
`default_nettype none

module chc_queue
   import chc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_en,
   input  wire entry_type push_data,
   output logic           full,
   input  wire logic      pop_en,
   output entry_type      pop_data,
   output logic           empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     level_ff, level_in;
   logic               do_push, do_pop;

   assign full     = (level_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (level_ff == '0);
   assign do_push  = push_en && !full;
   assign do_pop   = pop_en && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) level_in = level_ff + 1'b1;
      else if (do_pop && !do_push) level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/chc_back.sv -----
`default_nettype none

module chc_back
   import chc_pkg::*;
#(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        entry_valid,
   input  wire entry_type   entry,
   output logic             entry_pop,
   input  wire logic [15:0] target_heading,
   input  wire logic        hold_enable,
   input  wire logic [15:0] kp_gain,
   output logic             empty,
   input  wire logic        pop,
   output result_type       result
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [32:0] TAB_ROUND = 33'(1) << (31 - ANGLE_BITS);
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ROTATE  = 5'b00010,
      ST_SCALE   = 5'b00100,
      ST_PRODUCT = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [STEP_W-1:0]          step_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff;
   logic [ANGLE_BITS-1:0]      ang_ff;
   logic                       hdg_ff, drive_ff, status_ff;
   logic [15:0]                count_ff, heading_ff;
   logic signed [15:0]         err_ff;
   logic signed [23:0]         rate_ff;
   result_type                 res_ff;
   logic                       res_valid_ff;

   logic signed [CORDIC_W-1:0] x_init, y_init, x_shift, y_shift;
   logic [32:0]                tab_sum;
   logic [ANGLE_BITS-1:0]      step_angle;
   logic [15:0]                heading_round;
   logic signed [32:0]         product;
   logic                       res_free, last_step;

   assign x_init    = {{3{entry.xc[CENTER_W-1]}}, entry.xc, 8'b0};
   assign y_init    = {{3{entry.yc[CENTER_W-1]}}, entry.yc, 8'b0};
   assign x_shift   = x_ff >>> step_ff;
   assign y_shift   = y_ff >>> step_ff;
   assign tab_sum   = {1'b0, ATAN_TURN_TAB[TAB_IW'(step_ff)]} + TAB_ROUND;
   assign step_angle = ANGLE_BITS'(tab_sum >> (32 - ANGLE_BITS));
   assign last_step = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   // angle to a 16-bit fraction of a turn
   generate
      if (ANGLE_BITS > 16) begin : g_round
         logic [ANGLE_BITS:0] ang_sum;
         assign ang_sum = {1'b0, ang_ff} + ((ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 17));
         assign heading_round = ang_sum[ANGLE_BITS-16 +: 16];
      end else begin : g_widen
         assign heading_round = 16'(ang_ff) << (16 - ANGLE_BITS);
      end
   endgenerate

   assign product   = $signed({1'b0, kp_gain}) * err_ff;
   assign res_free  = !res_valid_ff || pop;
   assign entry_pop = (state_ff == ST_IDLE) && entry_valid;
   assign empty     = !res_valid_ff;
   assign result    = res_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               if (!entry.hdg) state_in = ST_EMIT;
               else if (entry.xc == '0 && entry.yc == '0) state_in = ST_SCALE;
               else state_in = ST_ROTATE;
            end
         end
         ST_ROTATE:  if (last_step) state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_PRODUCT;
         ST_PRODUCT: state_in = ST_EMIT;
         ST_EMIT:    if (res_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            step_ff    <= '0;
            hdg_ff     <= entry.hdg;
            drive_ff   <= entry.hdg && hold_enable;
            status_ff  <= entry.status;
            count_ff   <= entry.count;
            heading_ff <= '0;
            err_ff     <= '0;
            rate_ff    <= '0;
            // a zero vector takes the positive branch, so its angle stays 0
            if (entry.xc[CENTER_W-1]) begin
               x_ff   <= -x_init;
               y_ff   <= -y_init;
               ang_ff <= HALF_TURN;
            end else begin
               x_ff   <= x_init;
               y_ff   <= y_init;
               ang_ff <= '0;
            end
         end
         ST_ROTATE: begin
            step_ff <= step_ff + 1'b1;
            if (!y_ff[CORDIC_W-1]) begin
               x_ff   <= x_ff + y_shift;
               y_ff   <= y_ff - x_shift;
               ang_ff <= ang_ff + step_angle;
            end else begin
               x_ff   <= x_ff - y_shift;
               y_ff   <= y_ff + x_shift;
               ang_ff <= ang_ff - step_angle;
            end
         end
         ST_SCALE: begin
            heading_ff <= heading_round;
            err_ff     <= drive_ff ? $signed(target_heading - heading_round) : '0;
         end
         ST_PRODUCT: begin
            rate_ff <= product[31:8];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && res_free) begin
         res_ff.heading       <= heading_ff;
         res_ff.heading_valid <= hdg_ff;
         res_ff.drive_active  <= drive_ff;
         res_ff.heading_error <= err_ff;
         res_ff.turn_rate     <= rate_ff;
         res_ff.status        <= status_ff;
         res_ff.good_count    <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && res_free) res_valid_ff <= 1'b1;
         else if (pop) res_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- sv/compass_heading_with_hold.sv -----
// Magnetometer heading with hard-iron centering and heading hold.
// Input queue side: drive req_* with push; the transaction is taken on a
// clock edge with push high and full low. Result queue side: the oldest
// result sits on rsp_* while empty is low and leaves on an edge with pop high.
// Every transaction gives exactly one result, in order.
// Calibration transactions update the min/max trackers in the front end at
// acceptance and pass from the queue through the back end's emit state, as
// does a heading sample with sample_ok low; the back end takes one entry at a
// time. A good heading sample goes through an iterative CORDIC in the back end,
// one rotation per cycle, then the scale and product steps before it appears
// (a zero vector skips the rotations); the CORDIC unit handles one sample at
// a time. A two-entry queue sits between front and back.
// A stalled result (pop low) holds the back end; once the queue fills, full
// rises. Registers on the APB port: 0x0 target heading, 0x4 hold enable,
// 0x8 gain (Q8.8); write them only while the block is idle.
// Synchronous reset empties both queues, clears the calibration to zero and
// restarts the trackers; gain resets to 1.0, hold off, target 0.
`default_nettype none

module compass_heading_with_hold
   import chc_pkg::*;
#(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [15:0] req_x_raw,
   input  wire logic signed [15:0] req_y_raw,
   input  wire logic               req_sample_ok,
   output logic                    empty,
   input  wire logic               pop,
   output logic [15:0]             rsp_heading,
   output logic                    rsp_heading_valid,
   output logic                    rsp_drive_active,
   output logic signed [15:0]      rsp_heading_error,
   output logic signed [23:0]      rsp_turn_rate,
   output logic                    rsp_status,
   output logic [15:0]             rsp_good_count,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [15:0] target_ff;
   logic        hold_ff;
   logic [15:0] kp_ff;
   logic        csr_write;

   logic       queue_full, queue_empty, entry_push, entry_pop;
   entry_type  entry_in, entry_out;
   result_type result;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         hold_ff   <= 1'b0;
         kp_ff     <= KP_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_TARGET: target_ff <= pwdata[15:0];
            REG_HOLD:   hold_ff   <= pwdata[0];
            REG_KP:     kp_ff     <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TARGET: prdata = {16'b0, target_ff};
         REG_HOLD:   prdata = {31'b0, hold_ff};
         REG_KP:     prdata = {16'b0, kp_ff};
         default:    prdata = '0;
      endcase
   end

   chc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_func      (req_func),
      .req_x_raw     (req_x_raw),
      .req_y_raw     (req_y_raw),
      .req_sample_ok (req_sample_ok),
      .queue_full    (queue_full),
      .entry_push    (entry_push),
      .entry         (entry_in)
   );

   chc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (entry_push),
      .push_data (entry_in),
      .full      (queue_full),
      .pop_en    (entry_pop),
      .pop_data  (entry_out),
      .empty     (queue_empty)
   );

   chc_back #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (!queue_empty),
      .entry          (entry_out),
      .entry_pop      (entry_pop),
      .target_heading (target_ff),
      .hold_enable    (hold_ff),
      .kp_gain        (kp_ff),
      .empty          (empty),
      .pop            (pop),
      .result         (result)
   );

   assign rsp_heading       = result.heading;
   assign rsp_heading_valid = result.heading_valid;
   assign rsp_drive_active  = result.drive_active;
   assign rsp_heading_error = result.heading_error;
   assign rsp_turn_rate     = result.turn_rate;
   assign rsp_status        = result.status;
   assign rsp_good_count    = result.good_count;

endmodule

`default_nettype wire

// ----- sim/compass_heading_with_hold_tb.sv -----
`default_nettype none

module compass_heading_with_hold_tb
   import chc_pkg::*;
();

   localparam longint CYCLE_LIMIT = 400_000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 355;
   localparam int CAL_RUN_ITEMS = 40;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32
   localparam longint TURN_ATAN [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   localparam int PHASE_SEND_IDLE [5] = '{0, 78, 0, 7, 0};
   localparam int PHASE_STALL [5] = '{0, 0, 78, 7, 0};
   localparam logic PHASE_HOLD [5] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam logic [15:0] PHASE_TARGET [5] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000};
   localparam logic [15:0] PHASE_KP [5] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0100};

   typedef struct packed {
      logic [15:0]        heading;
      logic               valid;
      logic               drive;
      logic signed [15:0] error;
      logic signed [23:0] rate;
      logic               status;
      logic [15:0]        count;
   } compass_result_type;

   typedef enum logic {STEP_ITEM, STEP_REG} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [1:0]         reg_idx;
      logic [15:0]        reg_val;
      func_type           func;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               ok;
      logic               known;
      compass_result_type want;
   } script_row_type;

   localparam int SCRIPT_LEN = 28;
   localparam script_row_type DIRECTED [SCRIPT_LEN] = '{
      // after reset the calibration is zero, so the origin is the zero vector
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd0, 16'sd0, 1'b1, 1'b1,
        '{16'd0, 1'b1, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd0}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1, '0},
      // finish with nothing counted
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_END, 16'sh1234, -16'sd5, 1'b1, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b1, 16'd0}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_DATA, -16'sd1, -16'sd1, 1'b0, 1'b1, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_DATA, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd1}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_END, 16'sd0, 16'sd0, 1'b0, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd1}},
      '{STEP_REG, REG_TARGET, 16'h8000, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_REG, REG_HOLD, 16'h0001, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_REG, REG_KP, 16'hFFFF, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      // centered to zero, error is exactly half a turn at full gain
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1,
        '{16'd0, 1'b1, 1'b1, 16'sh8000, -24'sd8388480, 1'b0, 16'd1}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd0, 16'sh8000, 1'b0, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd1}},
      '{STEP_REG, REG_KP, 16'h0000, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, '0},
      '{STEP_REG, REG_TARGET, 16'hFFFF, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_REG, REG_KP, 16'h0100, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_START, -16'sd1, -16'sd1, 1'b1, 1'b1, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_DATA, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd1}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_DATA, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd2}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_DATA, 16'sd0, 16'sd0, 1'b0, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd2}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_CAL_END, -16'sd1, -16'sd1, 1'b0, 1'b1,
        '{16'd0, 1'b0, 1'b0, 16'sd0, 24'sd0, 1'b0, 16'd2}},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sh8000, 16'sd0, 1'b1, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd0, 16'sh8000, 1'b1, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, 16'sd1, 16'sd1, 1'b1, 1'b0, '0},
      '{STEP_REG, REG_HOLD, 16'h0000, FUNC_HEADING, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{STEP_ITEM, REG_TARGET, 16'h0, FUNC_HEADING, -16'sd1, -16'sd1, 1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   func_type req_func = FUNC_HEADING;
   logic signed [15:0] req_x_raw = '0;
   logic signed [15:0] req_y_raw = '0;
   logic req_sample_ok = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic [15:0] rsp_heading;
   logic rsp_heading_valid;
   logic rsp_drive_active;
   logic signed [15:0] rsp_heading_error;
   logic signed [23:0] rsp_turn_rate;
   logic rsp_status;
   logic [15:0] rsp_good_count;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // predictor copy of the block's registers and calibration state
   logic [15:0] hdg_target = 16'd0;
   logic hold_on = 1'b0;
   logic [15:0] kp = 16'd256;
   logic signed [15:0] cal_x_lo = '0, cal_x_hi = '0, cal_y_lo = '0, cal_y_hi = '0;
   logic signed [15:0] trk_x_lo = 16'sh7FFF, trk_x_hi = 16'sh8000;
   logic signed [15:0] trk_y_lo = 16'sh7FFF, trk_y_hi = 16'sh8000;
   logic [15:0] cal_count = 16'd0;

   compass_result_type outputs_due [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int fault_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int headings_valid = 0;
   int drives = 0;
   int finish_fails = 0;
   int full_stall_cycles = 0;
   bit saturated = 1'b0;
   longint cycle_count = 0;
   string field_name [7] = '{"heading", "heading_valid", "drive_active", "heading_error",
                            "turn_rate", "status", "good_count"};

   compass_heading_with_hold dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_func(req_func),
      .req_x_raw(req_x_raw),
      .req_y_raw(req_y_raw),
      .req_sample_ok(req_sample_ok),
      .empty(empty),
      .pop(pop),
      .rsp_heading(rsp_heading),
      .rsp_heading_valid(rsp_heading_valid),
      .rsp_drive_active(rsp_drive_active),
      .rsp_heading_error(rsp_heading_error),
      .rsp_turn_rate(rsp_turn_rate),
      .rsp_status(rsp_status),
      .rsp_good_count(rsp_good_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic note_failure(input string msg);
      fault_count++;
      if (fault_count <= 40) $display("ERROR: %s", msg);
   endtask

   // vectoring cordic, angle kept as a 16 bit fraction of a turn
   function automatic logic [15:0] turn_fraction(input longint xc, input longint yc);
      longint vx, vy, nx, ang, step_ang;
      if (xc == 0 && yc == 0) return 16'd0;
      vx = xc * 256;
      vy = yc * 256;
      ang = 0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         ang = 32768;
      end
      for (int i = 0; i < 16; i++) begin
         step_ang = (TURN_ATAN[i] + 32768) >>> 16;
         if (vy >= 0) begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            ang += step_ang;
         end else begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
            ang -= step_ang;
         end
         vx = nx;
      end
      return 16'(ang);
   endfunction

   function automatic compass_result_type compass_step(input func_type f,
         input logic signed [15:0] x, input logic signed [15:0] y, input logic ok);
      compass_result_type r;
      longint xc, yc, prod;
      r = '0;
      case (f)
         FUNC_HEADING: begin
            if (ok) begin
               // hard-iron center removed at twice the scale, no rounding
               xc = 2 * longint'(x) - (longint'(cal_x_hi) + longint'(cal_x_lo));
               yc = 2 * longint'(y) - (longint'(cal_y_hi) + longint'(cal_y_lo));
               r.heading = turn_fraction(xc, yc);
               r.valid = 1'b1;
               headings_valid++;
               if (hold_on) begin
                  r.drive = 1'b1;
                  r.error = hdg_target - r.heading;
                  prod = longint'(kp) * longint'(r.error);
                  r.rate = 24'(prod >>> 8);
                  drives++;
               end
            end
         end
         FUNC_CAL_START: begin
            trk_x_lo = 16'sh7FFF;
            trk_x_hi = 16'sh8000;
            trk_y_lo = 16'sh7FFF;
            trk_y_hi = 16'sh8000;
            cal_count = 16'd0;
         end
         FUNC_CAL_DATA: begin
            if (ok) begin
               if (x < trk_x_lo) trk_x_lo = x;
               if (x > trk_x_hi) trk_x_hi = x;
               if (y < trk_y_lo) trk_y_lo = y;
               if (y > trk_y_hi) trk_y_hi = y;
               if (cal_count != 16'hFFFF) cal_count++;
               else saturated = 1'b1;
            end
         end
         FUNC_CAL_END: begin
            if (cal_count == 16'd0) begin
               r.status = 1'b1;
               finish_fails++;
            end else begin
               cal_x_lo = trk_x_lo;
               cal_x_hi = trk_x_hi;
               cal_y_lo = trk_y_lo;
               cal_y_hi = trk_y_hi;
            end
         end
         default: begin
         end
      endcase
      r.count = cal_count;
      return r;
   endfunction

   function automatic logic signed [15:0] pick_axis();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return 16'sh7FFF;
      if (sel == 1) return 16'sh8000;
      if (sel < 4) return 16'(int'($urandom_range(512)) - 256);
      return 16'($urandom);
   endfunction

   task automatic offer(input func_type f, input logic signed [15:0] x,
         input logic signed [15:0] y, input logic ok, input logic known = 1'b0,
         input compass_result_type known_result = '0);
      compass_result_type prediction;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_func <= f;
      req_x_raw <= x;
      req_y_raw <= y;
      req_sample_ok <= ok;
      do @(posedge clock); while (full);
      prediction = compass_step(f, x, y, ok);
      outputs_due.push_back(known ? known_result : prediction);
      items_sent++;
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      do @(posedge clock); while (outputs_due.size() != 0);
   endtask

   // write, then read back through the same port
   task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
      logic [31:0] readback;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TARGET: hdg_target = val;
         REG_HOLD: hold_on = val[0];
         default: kp = val;
      endcase
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = (idx == REG_HOLD) ? {31'd0, val[0]} : {16'd0, val};
      if (prdata !== readback)
         note_failure($sformatf("register %0d read %0h, expected %0h", idx, prdata, readback));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // result side: check, then decide whether to pop next cycle
   always @(posedge clock) begin
      compass_result_type want;
      longint got_f [7];
      longint want_f [7];
      if (!reset) begin
         if (pop && !empty) begin
            if (outputs_due.size() == 0) begin
               note_failure($sformatf("transaction with nothing pending, heading %0d",
                                      rsp_heading));
            end else begin
               want = outputs_due.pop_front();
               got_f = '{rsp_heading, rsp_heading_valid, rsp_drive_active,
                         rsp_heading_error, rsp_turn_rate, rsp_status, rsp_good_count};
               want_f = '{want.heading, want.valid, want.drive, want.error,
                          want.rate, want.status, want.count};
               for (int i = 0; i < 7; i++)
                  if (got_f[i] !== want_f[i])
                     note_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                            results_checked, field_name[i], got_f[i],
                                            want_f[i]));
            end
            results_checked++;
         end
         if (push && full) full_stall_cycles++;
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                  outputs_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      int phase_end;
      int pick;
      logic [15:0] tgt;
      logic [15:0] gain;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < SCRIPT_LEN; s++) begin
         row = DIRECTED[s];
         if (row.kind == STEP_REG) begin
            wait_idle();
            reg_write(row.reg_idx, row.reg_val);
         end else begin
            offer(row.func, row.x, row.y, row.ok, row.known, row.want);
         end
      end

      // longer calibration run over random samples, then headings against it
      offer(FUNC_CAL_START, pick_axis(), pick_axis(), 1'b1);
      repeat (CAL_RUN_ITEMS) offer(FUNC_CAL_DATA, 16'($urandom), 16'($urandom), 1'b1);
      offer(FUNC_CAL_DATA, 16'sh8000, 16'sh7FFF, 1'b0);
      offer(FUNC_CAL_END, pick_axis(), pick_axis(), 1'b0);
      repeat (8) offer(FUNC_HEADING, pick_axis(), pick_axis(), 1'b1);

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         send_idle_pct = PHASE_SEND_IDLE[p];
         rsp_stall_pct = PHASE_STALL[p];
         tgt = (p == 2 || p == 4) ? 16'($urandom) : PHASE_TARGET[p];
         gain = (p == 2) ? 16'($urandom) : PHASE_KP[p];
         reg_write(REG_TARGET, tgt);
         reg_write(REG_HOLD, {15'd0, PHASE_HOLD[p]});
         reg_write(REG_KP, gain);
         // receiver backs off for a while so the block fills and pushes back
         if (p == 0 || p == 2) hold_token <= hold_token + 1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(19);
            if (pick < 10) begin
               repeat ($urandom_range(1, 8))
                  offer(FUNC_HEADING, pick_axis(), pick_axis(), $urandom_range(9) != 0);
            end else if (pick < 15) begin
               offer(FUNC_CAL_START, 16'($urandom), 16'($urandom), 1'($urandom));
               repeat ($urandom_range(1, 12))
                  offer(FUNC_CAL_DATA, pick_axis(), pick_axis(), $urandom_range(6) != 0);
               offer(FUNC_CAL_END, 16'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 18) begin
               offer(func_type'($urandom_range(3)), 16'($urandom), 16'($urandom),
                     1'($urandom));
            end else begin
               // stray finish or sample outside a calibration run
               offer($urandom_range(1) ? FUNC_CAL_END : FUNC_CAL_DATA, pick_axis(),
                     pick_axis(), 1'($urandom));
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions sent, %0d results checked: %0d valid headings, %0d with hold",
               items_sent, results_checked, headings_valid, drives);
      $display("%0d failed finishes, count saturation %s, input pushed back for %0d cycles",
               finish_fails, saturated ? "reached" : "missed", full_stall_cycles);
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
